// File: sv/drrip_stream_bypass_replacement_top_defines.svh
// Assertion helpers shared by the replacement block.
`ifndef DRRIP_STREAM_BYPASS_REPLACEMENT_TOP_DEFINES_SVH
`define DRRIP_STREAM_BYPASS_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define DSB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define DSB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/drrip_sb_pkg.sv
package drrip_sb_pkg;

  localparam int NUM_SETS    = 2048;
  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int NUM_WAYS    = 16;
  localparam int WAY_BITS    = $clog2(NUM_WAYS);
  localparam int LEADER_SETS = 64;
  localparam int SEL_BITS    = 10;
  localparam int ADDR_BITS   = 48;
  localparam int LFSR_BITS   = 16;

  localparam logic [SEL_BITS-1:0]  SEL_MAX    = {SEL_BITS{1'b1}};
  localparam logic [SEL_BITS-1:0]  SEL_MID    = SEL_MAX >> 1;
  localparam logic [LFSR_BITS-1:0] LFSR_SEED  = 16'hACE1;
  localparam logic [LFSR_BITS-1:0] LFSR_TAPS  = 16'hB400;
  localparam int                   RARE_BITS  = 5;

  localparam logic [SET_BITS-1:0] SRRIP_LEADER_END = SET_BITS'(LEADER_SETS / 2);
  localparam logic [SET_BITS-1:0] BRRIP_LEADER_END = SET_BITS'(LEADER_SETS);

  // Re-reference prediction values.
  localparam logic [1:0] RRPV_NEAR  = 2'd0;
  localparam logic [1:0] RRPV_LONG  = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic [NUM_WAYS-1:0][1:0] rrpv;
    logic [ADDR_BITS-1:0]     prev_addr;
    logic [ADDR_BITS:0]       stride;
    logic [1:0]               cnt;
  } set_row_t;

  localparam set_row_t ROW_RESET = '{
    rrpv:      {NUM_WAYS{RRPV_DISTANT}},
    prev_addr: '0,
    stride:    '0,
    cnt:       '0
  };

  typedef struct packed {
    logic fire;
    logic srrip_leader;
    logic brrip_leader;
    logic hit;
  } pol_req_t;

  typedef struct packed {
    logic use_brrip;
    logic rare;
  } pol_rsp_t;

endpackage

// File: sv/drrip_sb_policy.sv
`include "drrip_stream_bypass_replacement_top_defines.svh"

module drrip_sb_policy
  import drrip_sb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  pol_req_t req,
  output pol_rsp_t rsp
);

  logic [SEL_BITS-1:0]  sel;
  logic [LFSR_BITS-1:0] lfsr;
  logic [LFSR_BITS-1:0] lfsr_next;
  logic                 use_brrip;

  assign lfsr_next = {1'b0, lfsr[LFSR_BITS-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);

  // Followers take SRRIP while the selector sits below its midpoint.
  always_comb begin
    if (req.srrip_leader) begin
      use_brrip = 1'b0;
    end else if (req.brrip_leader) begin
      use_brrip = 1'b1;
    end else begin
      use_brrip = !(sel < SEL_MID);
    end
  end

  assign rsp.use_brrip = use_brrip;
  assign rsp.rare      = (lfsr_next[RARE_BITS-1:0] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sel  <= SEL_MID;
      lfsr <= LFSR_SEED;
    end else if (req.fire) begin
      if (use_brrip) begin
        lfsr <= lfsr_next;
      end
      if (!req.hit) begin
        if (req.srrip_leader && sel != SEL_MAX) begin
          sel <= sel + 1'b1;
        end else if (req.brrip_leader && !req.srrip_leader && sel != '0) begin
          sel <= sel - 1'b1;
        end
      end
    end
  end

  `DSB_ASSERT_IMP(a_lfsr_nonzero, 1'b1, lfsr != '0, "LFSR reached the all-zero lockup state")
  `DSB_ASSERT_NXT(a_sel_hold, !req.fire || req.hit, sel == $past(sel), "selector moved without a miss")
  `DSB_ASSERT_NXT(a_lfsr_hold, !(req.fire && use_brrip), lfsr == $past(lfsr), "LFSR advanced outside a BRRIP update")

endmodule

// File: sv/drrip_stream_bypass_replacement_top.sv
// Replacement-state engine for a 2048-set, 16-way last-level cache.
// Input channel (in_valid/in_stall) carries one request word: a victim query
// (opcode 0) or a state update after a hit or miss fill (opcode 1).
// Output channel (out_valid/out_stall) returns exactly one result word per
// request: the victim way on a query, the streaming flag and the inserted
// re-reference value on an update.
// Requests are handled one at a time. The set row is read from a single-port
// state memory, worked on by a small sequencer and written back. A query does
// one read, a scan of the 16 ways through one compare unit, ageing, write-back
// and result. An update does a read, a 49-bit stride subtract, compare and
// policy decision, write-back and result. The next request can be taken in the
// same cycle as the result appears. in_stall stays high until the result has
// entered the output register.
// After reset the block sweeps the state memory, one set per cycle, through all
// 2048 sets before it accepts the first request.
// A stalled receiver holds the result in the output register; the block then
// finishes at most one more request and waits with it until the slot frees.
`include "drrip_stream_bypass_replacement_top_defines.svh"

module drrip_stream_bypass_replacement_top
  import drrip_sb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [SET_BITS-1:0]  set_index,
  input  logic [WAY_BITS-1:0]  way_index,
  input  logic                 hit_flag,
  input  logic [ADDR_BITS-1:0] phys_addr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WAY_BITS-1:0]  victim_way,
  output logic                 streaming,
  output logic [1:0]           insert_value
);

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_READ   = 9'b000000100,
    ST_SCAN   = 9'b000001000,
    ST_AGE    = 9'b000010000,
    ST_DELTA  = 9'b000100000,
    ST_DECIDE = 9'b001000000,
    ST_WRITE  = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  set_row_t mem [NUM_SETS];
  set_row_t rd;
  set_row_t wr_row;
  set_row_t aged_row;
  set_row_t upd_row;

  logic                 op_q;
  logic [SET_BITS-1:0]  set_q;
  logic [WAY_BITS-1:0]  way_q;
  logic                 hit_q;
  logic [ADDR_BITS-1:0] addr_q;

  logic [SET_BITS-1:0]  clr_cnt;
  logic [WAY_BITS-1:0]  way_cnt;
  logic [1:0]           max_q;
  logic [WAY_BITS-1:0]  vic_q;
  logic [ADDR_BITS:0]   delta_q;

  logic [WAY_BITS-1:0]  res_victim;
  logic                 res_stream;
  logic [1:0]           res_ins;

  logic                 mem_we;
  logic [SET_BITS-1:0]  mem_wa;
  set_row_t             mem_wd;
  logic                 out_free;

  logic [1:0]           cur_rrpv;
  logic [1:0]           age_add;
  logic                 repeat_stride;
  logic [1:0]           cnt_next;
  logic                 stream_now;
  logic [1:0]           ins_policy;
  logic [1:0]           ins_final;
  logic [1:0]           written;

  pol_req_t pol_req;
  pol_rsp_t pol_rsp;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Shared compare unit for the victim scan, one way per cycle.
  assign cur_rrpv = rd.rrpv[way_cnt];
  assign age_add  = RRPV_DISTANT - max_q;

  // Stride detector: a repeated nonzero delta counts up, anything else down.
  assign repeat_stride = (delta_q == rd.stride) && (delta_q != '0);
  always_comb begin
    if (repeat_stride) begin
      cnt_next = (rd.cnt == 2'd3) ? rd.cnt : rd.cnt + 2'd1;
    end else begin
      cnt_next = (rd.cnt == 2'd0) ? rd.cnt : rd.cnt - 2'd1;
    end
  end
  assign stream_now = cnt_next[1];

  assign pol_req.fire         = (state == ST_DECIDE);
  assign pol_req.srrip_leader = (set_q < SRRIP_LEADER_END);
  assign pol_req.brrip_leader = (set_q < BRRIP_LEADER_END);
  assign pol_req.hit          = hit_q;

  drrip_sb_policy u_policy (
    .clk (clk),
    .rst (rst),
    .req (pol_req),
    .rsp (pol_rsp)
  );

  always_comb begin
    if (pol_rsp.use_brrip) begin
      ins_policy = pol_rsp.rare ? RRPV_LONG : RRPV_DISTANT;
    end else begin
      ins_policy = RRPV_LONG;
    end
    ins_final = stream_now ? RRPV_DISTANT : ins_policy;
    written   = hit_q ? RRPV_NEAR : ins_final;
  end

  always_comb begin
    aged_row = rd;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row.rrpv[w] = rd.rrpv[w] + age_add;
    end
  end

  always_comb begin
    upd_row             = rd;
    upd_row.rrpv[way_q] = written;
    upd_row.prev_addr   = addr_q;
    upd_row.stride      = delta_q;
    upd_row.cnt         = cnt_next;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = set_q;
    mem_wd = wr_row;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        mem_wd = ROW_RESET;
      end
      ST_WRITE: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state == ST_READ) begin
      rd <= mem[set_q];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_BITS'(NUM_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = (op_q == OP_QUERY) ? ST_SCAN : ST_DELTA;
      end
      ST_SCAN: begin
        if (way_cnt == WAY_BITS'(NUM_WAYS - 1)) begin
          state_next = ST_AGE;
        end
      end
      ST_AGE:    state_next = ST_WRITE;
      ST_DELTA:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_q   <= opcode;
        set_q  <= set_index;
        way_q  <= way_index;
        hit_q  <= hit_flag;
        addr_q <= phys_addr;
      end
      ST_READ: begin
        way_cnt <= '0;
        max_q   <= RRPV_NEAR;
        vic_q   <= '0;
      end
      ST_SCAN: begin
        // Strictly greater keeps the lowest way among equal maxima.
        if (cur_rrpv > max_q) begin
          max_q <= cur_rrpv;
          vic_q <= way_cnt;
        end
        way_cnt <= way_cnt + 1'b1;
      end
      ST_AGE: begin
        wr_row     <= aged_row;
        res_victim <= vic_q;
        res_stream <= 1'b0;
        res_ins    <= 2'd0;
      end
      ST_DELTA: begin
        delta_q <= {1'b0, addr_q} - {1'b0, rd.prev_addr};
      end
      ST_DECIDE: begin
        wr_row     <= upd_row;
        res_victim <= '0;
        res_stream <= stream_now;
        res_ins    <= written;
      end
      ST_DONE: begin
        if (out_free) begin
          victim_way   <= res_victim;
          streaming    <= res_stream;
          insert_value <= res_ins;
        end
      end
      default: begin
      end
    endcase
  end

  `DSB_ASSERT_NXT(a_accept_reads, in_valid && !in_stall, state == ST_READ,
                  "accepted word did not start a row read")
  `DSB_ASSERT_IMP(a_stream_insert, out_valid && streaming,
                  insert_value == RRPV_DISTANT || insert_value == RRPV_NEAR,
                  "streaming update inserted below distant")
  `DSB_ASSERT_IMP(a_query_fields, out_valid && victim_way != '0,
                  !streaming && insert_value == 2'd0,
                  "query result carries update fields")

endmodule
